// ----- sv/stfs_pkg.sv -----
// Shared types and constants for the seek table floor search block.
// Has no dependencies; every other file imports it.
package stfs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    // Field widths and the fixed-point scale of the seek time.
    localparam int DATA_W           = 32;
    localparam int Q_FRAC           = 16;
    localparam int UNITS_PER_SECOND = 88200;
    localparam int UNITS_W          = $clog2(UNITS_PER_SECOND + 1);
    localparam int PROD_W           = DATA_W + UNITS_W;

    // Transaction kinds.
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;        // Reset the entry count.
        logic append;       // Write the input entry at the count and bump it.
        logic load_query;   // Multiply the seek time into the product register.
        logic init_search;  // Saturate the target and set up the search range.
        logic probe;        // Read the middle entry of the range.
        logic compare;      // Narrow the range on the probed position.
        logic fetch;        // Read the entry at the low bound.
        logic emit;         // Load the found offset into the result register.
        logic emit_empty;   // Load the empty-table answer.
    } stfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic range_done;
    } stfs_status_t;

endpackage

// ----- sv/stfs_dpath.sv -----
// Datapath of the seek table floor search: entry memories, target scaling,
// search bounds and result registers. Depends on stfs_pkg.
module stfs_dpath
    import stfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  stfs_cmd_t           cmd,
    input  logic [DATA_W-1:0]   entry_offset,
    input  logic [DATA_W-1:0]   entry_position,
    input  logic [DATA_W-1:0]   seconds_q16,
    output stfs_status_t        status,
    output logic [DATA_W-1:0]   seek_offset,
    output logic                table_empty
);

    // Entry memories; contents are undefined until written.
    logic [DATA_W-1:0] offset_mem   [TABLE_DEPTH];
    logic [DATA_W-1:0] position_mem [TABLE_DEPTH];

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [PROD_W-1:0]  product_reg;
    logic [DATA_W-1:0]  target_reg;
    logic [ADDR_W-1:0]  lo_reg;
    logic [ADDR_W-1:0]  lo_next;
    logic [ADDR_W-1:0]  hi_reg;
    logic [ADDR_W-1:0]  hi_next;
    logic [ADDR_W-1:0]  mid_reg;
    logic [DATA_W-1:0]  rd_offset_reg;
    logic [DATA_W-1:0]  rd_position_reg;
    logic [DATA_W-1:0]  seek_offset_reg;
    logic               table_empty_reg;

    logic [ADDR_W:0]        mid_sum;
    logic [ADDR_W-1:0]      mid;
    logic [ADDR_W-1:0]      rd_addr;
    logic [PROD_W-Q_FRAC-1:0] units;
    logic [DATA_W-1:0]      target_sat;
    logic [COUNT_W-1:0]     last_index;

    // Upper middle of the current range.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + {{ADDR_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[ADDR_W:1];

    // Drop the fraction bits and saturate to the target width.
    assign units      = product_reg[PROD_W-1:Q_FRAC];
    assign target_sat = (|units[PROD_W-Q_FRAC-1:DATA_W]) ? {DATA_W{1'b1}}
                                                        : units[DATA_W-1:0];

    assign last_index = count_reg - {{(COUNT_W-1){1'b0}}, 1'b1};
    assign rd_addr    = cmd.fetch ? lo_reg : mid;

    // Status toward the controller.
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign status.range_done = (lo_reg >= hi_reg);

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
        end
    end

    // Search range update.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.init_search)
        begin
            lo_next = '0;
            hi_next = last_index[ADDR_W-1:0];
        end
        else if (cmd.compare)
        begin
            if (rd_position_reg <= target_reg)
            begin
                lo_next = mid_reg;
            end
            else
            begin
                hi_next = mid_reg - {{(ADDR_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // Control register: the entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Memory write port, at the current count.
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            offset_mem[count_reg[ADDR_W-1:0]]   <= entry_offset;
            position_mem[count_reg[ADDR_W-1:0]] <= entry_position;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (cmd.probe || cmd.fetch)
        begin
            rd_offset_reg   <= offset_mem[rd_addr];
            rd_position_reg <= position_mem[rd_addr];
        end
    end

    // Payload registers: scaling, search bounds and result.
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            product_reg <= PROD_W'(seconds_q16) * PROD_W'(UNITS_PER_SECOND);
        end
        if (cmd.init_search)
        begin
            target_reg <= target_sat;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.emit)
        begin
            seek_offset_reg <= rd_offset_reg;
            table_empty_reg <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            seek_offset_reg <= '0;
            table_empty_reg <= 1'b1;
        end
    end

    assign seek_offset = seek_offset_reg;
    assign table_empty = table_empty_reg;

endmodule

// ----- sv/stfs_ctrl.sv -----
// Controller of the seek table floor search: accepts transactions and
// sequences the scaling, the probe loop and the result. Depends on stfs_pkg.
module stfs_ctrl
    import stfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    kind,
    input  stfs_status_t  status,
    output stfs_cmd_t     cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PROBE,
        ST_COMPARE,
        ST_FETCH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;
    kind_t  kind_in;

    assign accept  = start && (state_reg == ST_IDLE);
    assign kind_in = kind_t'(kind);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind_in)
                        KIND_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        KIND_APPEND:
                        begin
                            cmd.append = !status.count_full;
                        end
                        KIND_QUERY:
                        begin
                            cmd.load_query = 1'b1;
                            state_next     = ST_SCALE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCALE:
            begin
                if (status.count_zero)
                begin
                    cmd.emit_empty = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.init_search = 1'b1;
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.range_done)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_PROBE;
            end
            ST_FETCH:
            begin
                cmd.emit   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and the registered result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ----- sv/seek_table_floor_search.sv -----
// Seek table floor search, top level: joins the controller and the datapath.
// Depends on stfs_pkg, stfs_ctrl and stfs_dpath.
//
// A transaction is taken when start is high and busy is low. Clear and
// append finish in the accepting cycle and never hold busy. A seek query
// holds busy and answers with a one-cycle done strobe carrying seek_offset
// and table_empty; the receiver cannot stall it, so it must take the result
// in that cycle. On acceptance a query multiplies the seek time by 88200
// into the product register; ST_SCALE saturates it, and the floor search
// then makes one probe per halving of the range, each probe being a
// registered read of the single entry memory port followed by a compare,
// and ends with one read and one result load. For an empty table, ST_SCALE
// loads the empty answer instead, and done follows from the done register.
module seek_table_floor_search
    import stfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [DATA_W-1:0]  entry_offset,
    input  logic [DATA_W-1:0]  entry_position,
    input  logic [DATA_W-1:0]  seconds_q16,
    output logic               done,
    output logic [DATA_W-1:0]  seek_offset,
    output logic               table_empty
);

    stfs_cmd_t    cmd;
    stfs_status_t status;

    // Sequencing of each transaction.
    stfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Table storage, scaling and search.
    stfs_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .entry_offset   (entry_offset),
        .entry_position (entry_position),
        .seconds_q16    (seconds_q16),
        .status         (status),
        .seek_offset    (seek_offset),
        .table_empty    (table_empty)
    );

endmodule

// ----- bench/seek_table_floor_search_checker.sv -----
// Checker for the seek table floor search block: watches the command and result ports,
// keeps its own copy of the seek table and compares every answer with its prediction.
// Depends on stfs_pkg for widths, table depth, the time scale and the transaction kinds.
module seek_table_floor_search_checker
    import stfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        kind,
    input  logic [DATA_W-1:0] entry_offset,
    input  logic [DATA_W-1:0] entry_position,
    input  logic [DATA_W-1:0] seconds_q16,
    input  logic              done,
    input  logic [DATA_W-1:0] seek_offset,
    input  logic              table_empty,
    output int                mismatch_count,
    output int                pending_answers
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic              empty;
    } seek_answer_t;

    // Shadow copy of the seek table.
    logic [DATA_W-1:0] offsets_copy   [TABLE_DEPTH];
    logic [DATA_W-1:0] positions_copy [TABLE_DEPTH];
    int                entries;

    // Answers owed by the block, oldest first.
    seek_answer_t expected_answers [$];

    // Seek time in Q16.16 seconds to position units, floored and saturated to 32 bits.
    function automatic logic [DATA_W-1:0] scaled_target(input logic [DATA_W-1:0] q);
        logic [63:0] units;
        units = (64'(q) * 64'(UNITS_PER_SECOND)) >> Q_FRAC;
        return (units > 64'(32'hFFFF_FFFF)) ? '1 : units[DATA_W-1:0];
    endfunction

    // Upper-middle binary search for the last entry at or below the target. The probe
    // order is fixed, so an unsorted table still gives one well-defined answer, and
    // a target below every entry ends on entry 0.
    function automatic logic [DATA_W-1:0] floor_offset(input logic [DATA_W-1:0] target);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = entries - 1;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (positions_copy[mid] <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return offsets_copy[lo];
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("%0t ns: seek answer mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seek_answer_t answer;
        if (!rst_n)
        begin
            entries = 0;
            expected_answers.delete();
            mismatch_count = 0;
            pending_answers = 0;
        end
        else
        begin
            // Result side: a strobed answer is checked against the oldest prediction.
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch($sformatf("answer %08h empty %0b with no query outstanding",
                                              seek_offset, table_empty));
                end
                else
                begin
                    answer = expected_answers.pop_front();
                    if (seek_offset !== answer.offset)
                        report_mismatch($sformatf("seek_offset %08h, predicted %08h",
                                                  seek_offset, answer.offset));
                    if (table_empty !== answer.empty)
                        report_mismatch($sformatf("table_empty %0b, predicted %0b",
                                                  table_empty, answer.empty));
                end
            end

            // Command side: an accepted clear or append updates the shadow table (an append
            // only while it has room), and an accepted query queues its answer.
            if (start && !busy)
            begin
                case (kind)
                    KIND_CLEAR:
                        entries = 0;
                    KIND_APPEND:
                        if (entries < TABLE_DEPTH)
                        begin
                            offsets_copy[entries]   = entry_offset;
                            positions_copy[entries] = entry_position;
                            entries++;
                        end
                    KIND_QUERY:
                        if (entries == 0)
                            expected_answers.push_back('{offset: '0, empty: 1'b1});
                        else
                            expected_answers.push_back(
                                '{offset: floor_offset(scaled_target(seconds_q16)),
                                  empty: 1'b0});
                    default:
                        ;
                endcase
            end
            pending_answers = expected_answers.size();
        end
    end

endmodule

// ----- bench/seek_table_floor_search_tb.sv -----
// Testbench top for the seek table floor search block: clock, reset, bursty command
// stimulus and the final verdict. Depends on stfs_pkg, seek_table_floor_search and
// seek_table_floor_search_checker.
module seek_table_floor_search_tb;
    import stfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The one kind value the block ignores.
    localparam logic [1:0]        KIND_IGNORED = 2'd3;
    localparam logic [DATA_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              start          = 1'b0;
    logic [1:0]        kind           = KIND_CLEAR;
    logic [DATA_W-1:0] entry_offset   = '0;
    logic [DATA_W-1:0] entry_position = '0;
    logic [DATA_W-1:0] seconds_q16    = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] seek_offset;
    logic              table_empty;
    int                mismatch_count;
    int                pending_answers;

    // Stimulus bookkeeping: transactions sent, the current burst, and the positions
    // stored since the last clear, used to aim queries at table entries.
    int                commands_sent = 0;
    int                burst_left    = 0;
    logic [DATA_W-1:0] stored_positions [$];

    always #5 clk = ~clk;

    seek_table_floor_search uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .entry_offset   (entry_offset),
        .entry_position (entry_position),
        .seconds_q16    (seconds_q16),
        .done           (done),
        .seek_offset    (seek_offset),
        .table_empty    (table_empty)
    );

    seek_table_floor_search_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .entry_offset    (entry_offset),
        .entry_position  (entry_position),
        .seconds_q16     (seconds_q16),
        .done            (done),
        .seek_offset     (seek_offset),
        .table_empty     (table_empty),
        .mismatch_count  (mismatch_count),
        .pending_answers (pending_answers)
    );

    // Smallest seek time whose scaled target reaches the given position.
    function automatic logic [DATA_W-1:0] seconds_at(input logic [DATA_W-1:0] pos);
        logic [63:0] q;
        q = ((64'(pos) << Q_FRAC) + 64'(UNITS_PER_SECOND - 1)) / 64'(UNITS_PER_SECOND);
        return (q > 64'(ALL_ONES)) ? ALL_ONES : q[DATA_W-1:0];
    endfunction

    // Seek time for a query: mostly on or next to a stored position, else at or
    // below the first entry, anywhere, or at the saturating maximum.
    function automatic logic [DATA_W-1:0] aimed_seconds();
        int r;
        r = $urandom_range(0, 99);
        if (stored_positions.size() == 0 || (r >= 75 && r < 90))
            return $urandom;
        if (r < 60)
            return seconds_at(stored_positions[$urandom_range(0, stored_positions.size() - 1)])
                   + DATA_W'($urandom_range(0, 2)) - 1;
        if (r < 75)
            return $urandom_range(0, seconds_at(stored_positions[0]));
        return ALL_ONES;
    endfunction

    // Presents one transaction and holds it until accepted; between bursts start
    // drops for a random gap.
    task automatic send_command(input logic [1:0] k, input logic [DATA_W-1:0] off,
                                input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] sec);
        start          <= 1'b1;
        kind           <= k;
        entry_offset   <= off;
        entry_position <= pos;
        seconds_q16    <= sec;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k != KIND_IGNORED)
            commands_sent++;
        if (k == KIND_CLEAR)
            stored_positions.delete();
        else if (k == KIND_APPEND && stored_positions.size() < TABLE_DEPTH)
            stored_positions.push_back(pos);

        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // Off-pattern traffic: ignored kinds, out-of-order appends and blind queries.
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_command(KIND_IGNORED, $urandom, $urandom, $urandom);
            1: send_command(KIND_APPEND, $urandom, $urandom, $urandom);
            default: send_command(KIND_QUERY, $urandom, $urandom, $urandom);
        endcase
    endtask

    // Clear, build a non-decreasing table with random content and some noise, querying it along the way, then query it.
    task automatic build_and_search(input int entries, input bit high_range);
        logic [DATA_W-1:0] pos;
        logic [DATA_W-1:0] step;
        send_command(KIND_CLEAR, $urandom, $urandom, $urandom);
        pos = high_range ? $urandom : $urandom_range(0, 5000);
        for (int i = 0; i < entries; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            send_command(KIND_APPEND, $urandom, pos, $urandom);
            if ($urandom_range(0, 5) == 0)
                send_command(KIND_QUERY, $urandom, $urandom, aimed_seconds());
            step = ($urandom_range(0, 7) == 0) ? '0
                   : $urandom_range(1, high_range ? (1 << 24) : 4000);
            pos = (ALL_ONES - pos < step) ? ALL_ONES : pos + step;
        end
        repeat ($urandom_range(2, 8))
            send_command(KIND_QUERY, $urandom, $urandom, aimed_seconds());
    endtask

    initial
    begin
        logic [DATA_W-1:0] pos;
        int                random_goal;
        int                drain_wait;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: queries on an empty table at both seek extremes, an ignored kind.
        send_command(KIND_QUERY, '0, '0, '0);
        send_command(KIND_QUERY, ALL_ONES, ALL_ONES, ALL_ONES);
        send_command(KIND_IGNORED, '0, '0, '0);
        // Small sorted table: target below every entry falls back to the first,
        // a saturated seek time lands on the last, and exact boundaries on each side.
        send_command(KIND_APPEND, ALL_ONES, 32'd1000, '0);
        send_command(KIND_QUERY, '0, '0, '0);
        send_command(KIND_APPEND, '0, 32'd2000, ALL_ONES);
        send_command(KIND_APPEND, 32'hA5A5_A5A5, ALL_ONES, '0);
        send_command(KIND_QUERY, '0, '0, ALL_ONES);
        send_command(KIND_QUERY, '0, '0, seconds_at(32'd2000));
        send_command(KIND_QUERY, '0, '0, seconds_at(32'd2000) - 1);
        send_command(KIND_QUERY, '0, '0, seconds_at(ALL_ONES) - 1);
        send_command(KIND_IGNORED, ALL_ONES, ALL_ONES, ALL_ONES);
        // Clear leaves the table empty again.
        send_command(KIND_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES);
        send_command(KIND_QUERY, '0, '0, seconds_at(32'd2000));
        // Unsorted appends: the answer follows the fixed probe order.
        send_command(KIND_APPEND, 32'd11, 32'd500, '0);
        send_command(KIND_APPEND, 32'd22, 32'd100, '0);
        send_command(KIND_APPEND, 32'd33, 32'd900, '0);
        send_command(KIND_APPEND, 32'd44, 32'd50, '0);
        send_command(KIND_QUERY, '0, '0, seconds_at(32'd100));
        send_command(KIND_QUERY, '0, '0, seconds_at(32'd600));
        send_command(KIND_QUERY, '0, '0, $urandom);
        send_command(KIND_CLEAR, '0, '0, '0);

        // Full table: appends past capacity are dropped, then the deepest searches.
        pos = $urandom_range(0, 1000);
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
        begin
            send_command(KIND_APPEND, $urandom, pos, $urandom);
            pos = pos + DATA_W'($urandom_range(1, 5000));
        end
        send_command(KIND_QUERY, '0, '0, ALL_ONES);
        send_command(KIND_QUERY, '0, '0, '0);
        repeat (12)
            send_command(KIND_QUERY, $urandom, $urandom, aimed_seconds());

        // Random: mostly well-formed tables of random size and content, some noise.
        random_goal = commands_sent + 150;
        while (commands_sent < random_goal)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat (3)
                    send_noise();
            else
                build_and_search(($urandom_range(0, 4) == 0) ? $urandom_range(17, 64)
                                                             : $urandom_range(1, 16),
                                 $urandom_range(0, 3) == 0);
        end
        start <= 1'b0;

        // Drain outstanding answers, then allow for a full-table search latency.
        drain_wait = 0;
        while (pending_answers != 0 && drain_wait < 1000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (40)
            @(posedge clk);
        if (pending_answers != 0)
            $display("%0d seek answers never arrived", pending_answers);

        if (mismatch_count == 0 && pending_answers == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/stfs_pkg.sv
sv/stfs_dpath.sv
sv/stfs_ctrl.sv
sv/seek_table_floor_search.sv
bench/seek_table_floor_search_checker.sv
bench/seek_table_floor_search_tb.sv
